>>> src/wmfp_pkg.sv
package wmfp_pkg;

  localparam int ZOOM_COUNT = 17;
  localparam logic [4:0] ZOOM_MAX = 5'(ZOOM_COUNT - 1);
  localparam logic [10:0] TILE_RESET = 11'd256;
  localparam logic [10:0] TILE_MAX = 11'd1024;

  localparam logic signed [30:0] LON_MAX = 31'sd754974720;
  localparam logic signed [30:0] LAT_MAX = 31'sd356730169;
  localparam logic [34:0] DEG2RAD_Q40 = 35'd19190098068;
  localparam logic [29:0] LN2_OVER_PI_Q32 = 30'd947622687;

  localparam int CW = 33;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam int DIV_BITS = 36;
  localparam int LOG_STEPS = 30;
  localparam logic [40:0] X_RECIP = 41'd1563749870615;
  localparam int V_W = 43;
  localparam int OUT_W = 35;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  typedef struct packed {
    logic [10:0]    t;
    logic [4:0]     z;
    logic           south;
    logic [V_W-1:0] v;
  } side_t;

  function automatic logic signed [CW-1:0] cordic_atan(input int unsigned idx);
    logic signed [CW-1:0] a;
    case (idx)
      0: a = 33'sh03243F6A8;
      1: a = 33'sh01DAC6705;
      2: a = 33'sh00FADBAFD;
      3: a = 33'sh007F56EA6;
      4: a = 33'sh003FEAB76;
      5: a = 33'sh001FFD55B;
      6: a = 33'sh000FFFAAA;
      7: a = 33'sh0007FFF55;
      8: a = 33'sh0003FFFEA;
      9: a = 33'sh0001FFFFD;
      10: a = 33'sh0000FFFFF;
      11: a = 33'sh00007FFFF;
      12: a = 33'sh00003FFFF;
      13: a = 33'sh00001FFFF;
      14: a = 33'sh00000FFFF;
      15: a = 33'sh000007FFF;
      16: a = 33'sh000003FFF;
      17: a = 33'sh000001FFF;
      18: a = 33'sh000000FFF;
      19: a = 33'sh0000007FF;
      20: a = 33'sh0000003FF;
      21: a = 33'sh0000001FF;
      22: a = 33'sh0000000FF;
      23: a = 33'sh00000007F;
      24: a = 33'sh00000003F;
      25: a = 33'sh00000001F;
      26: a = 33'sh00000000F;
      27: a = 33'sh000000007;
      28: a = 33'sh000000003;
      29: a = 33'sh000000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> src/web_mercator_forward_projection_core.sv
// Web Mercator forward projection: each request of longitude, latitude (signed Q9.22 degrees)
// and zoom gives one result of global pixel x and y with 8 fraction bits, for a map of
// 2^zoom tiles per side, each tile as wide as the configured tile edge. One request is taken
// every cycle while the result side does not stall; a result passes 3 input stages,
// the 30-stage CORDIC, the 37-stage quotient, 32 stages of log2, 3 stages forming y and the
// 3-stage reciprocal multiply that divides x by 360. Backpressure on the result side freezes
// the whole pipeline, the last stage being the output register.
// Longitude saturates at +-180 degrees, latitude at +-85.0511 degrees, zoom at 16, and the
// tile edge to the range 1..1024.
module web_mercator_forward_projection_core import wmfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i,     // tile edge in pixels
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // longitude, latitude, zoom
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // pixel_x, pixel_y
);

  logic        en;
  logic [10:0] tile_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q <= TILE_RESET;
    end else if (cfg_valid_i) begin
      tile_q <= cfg_data_i;
    end
  end

  // clamp inputs
  logic signed [30:0] lon, lat, lon_c, lat_c;
  logic [4:0]         zin, zc;
  logic [10:0]        tc;
  logic [31:0]        usum;

  always_comb begin
    lon = s_axis_tdata[30:0];
    lat = s_axis_tdata[61:31];
    zin = s_axis_tdata[66:62];
    if (lon > LON_MAX) begin
      lon_c = LON_MAX;
    end else if (lon < -LON_MAX) begin
      lon_c = -LON_MAX;
    end else begin
      lon_c = lon;
    end
    if (lat > LAT_MAX) begin
      lat_c = LAT_MAX;
    end else if (lat < -LAT_MAX) begin
      lat_c = -LAT_MAX;
    end else begin
      lat_c = lat;
    end
    zc = (zin > ZOOM_MAX) ? ZOOM_MAX : zin;
    if (tile_q == 11'd0) begin
      tc = 11'd1;
    end else if (tile_q > TILE_MAX) begin
      tc = TILE_MAX;
    end else begin
      tc = tile_q;
    end
    usum = {lon_c[30], lon_c} + {1'b0, LON_MAX};
  end

  logic        v0_q, south0_q;
  logic [30:0] u0_q;
  logic [28:0] alat0_q;
  logic [4:0]  z0_q;
  logic [10:0] t0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u0_q     <= usum[30:0];
      alat0_q  <= lat_c[30] ? 29'(-lat_c) : lat_c[28:0];
      south0_q <= lat_c[30];
      z0_q     <= zc;
      t0_q     <= tc;
    end
  end

  // products for x and for degrees to radians
  logic        v1_q, south1_q;
  logic [41:0] q1_q;
  logic [46:0] plo1_q;
  logic [45:0] phi1_q;
  logic [4:0]  z1_q;
  logic [10:0] t1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_q     <= u0_q * t0_q;
      plo1_q   <= alat0_q * DEG2RAD_Q40[17:0];
      phi1_q   <= alat0_q * DEG2RAD_Q40[34:18];
      south1_q <= south0_q;
      z1_q     <= z0_q;
      t1_q     <= t0_q;
    end
  end

  logic [63:0]    phsum;
  logic [V_W-1:0] vx;
  logic           v2_q;
  logic [30:0]    phi2_q;
  side_t          s2_q;

  always_comb begin
    phsum = {phi1_q, 18'd0} + {17'd0, plo1_q};
    if (z1_q >= 5'd14) begin
      vx = V_W'(q1_q) << (z1_q - 5'd14);
    end else begin
      vx = V_W'(q1_q) >> (5'd14 - z1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phi2_q     <= phsum[62:32];
      s2_q.t     <= t1_q;
      s2_q.z     <= z1_q;
      s2_q.south <= south1_q;
      s2_q.v     <= vx;
    end
  end

  logic                 cv, dv, lv;
  side_t                cs, ds, ls;
  logic signed [CW-1:0] cx, cy;
  logic                 dsat;
  logic [DIV_BITS-1:0]  dm;
  logic [30:0]          lp;

  wmfp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .side_i  (s2_q),
    .phi_i   ({2'b00, phi2_q}),
    .valid_o (cv),
    .side_o  (cs),
    .cx_o    (cx),
    .cy_o    (cy)
  );

  wmfp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv),
    .side_i  (cs),
    .cx_i    (cx),
    .cy_i    (cy),
    .valid_o (dv),
    .side_o  (ds),
    .sat_o   (dsat),
    .m_o     (dm)
  );

  wmfp_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .side_i  (ds),
    .sat_i   (dsat),
    .m_i     (dm),
    .valid_o (lv),
    .side_o  (ls),
    .p_o     (lp)
  );

  // y = w * tile * 2^zoom / 2^23
  logic           vw_q, vm_q, vy_q;
  logic [31:0]    w_q;
  logic [42:0]    wt_q;
  logic [OUT_W-1:0] y_q;
  side_t          sw_q, sm_q;
  logic [V_W-1:0] vy_xq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= 1'b0;
      vm_q <= 1'b0;
      vy_q <= 1'b0;
    end else if (en) begin
      vw_q <= lv;
      vm_q <= vw_q;
      vy_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q   <= ls.south ? ({1'b0, ONE_Q30} + {1'b0, lp}) : ({1'b0, ONE_Q30} - {1'b0, lp});
      sw_q  <= ls;
      wt_q  <= w_q * sw_q.t;
      sm_q  <= sw_q;
      y_q   <= OUT_W'(wt_q >> (5'd23 - sm_q.z));
      vy_xq <= sm_q.v;
    end
  end

  logic [OUT_W-1:0] px, py;

  wmfp_xdiv u_xdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vy_q),
    .v_i     (vy_xq),
    .y_i     (y_q),
    .valid_o (m_axis_tvalid),
    .x_o     (px),
    .y_o     (py)
  );

  assign m_axis_tdata = {2'b00, py, px};

endmodule

>>> src/wmfp_cordic.sv
module wmfp_cordic import wmfp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic signed [CW-1:0] phi_i,
  output logic                 valid_o,
  output side_t                side_o,
  output logic signed [CW-1:0] cx_o,
  output logic signed [CW-1:0] cy_o
);

  logic signed [CW-1:0] x_q [CORDIC_STEPS];
  logic signed [CW-1:0] y_q [CORDIC_STEPS];
  logic signed [CW-1:0] z_q [CORDIC_STEPS];
  logic                 v_q [CORDIC_STEPS];
  side_t                s_q [CORDIC_STEPS];

  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_stage
    logic signed [CW-1:0] xp, yp, zp, xn, yn, zn;
    logic                 vp;
    side_t                sp;

    if (gi == 0) begin : g_first
      assign xp = CORDIC_GAIN;
      assign yp = '0;
      assign zp = phi_i;
      assign vp = valid_i;
      assign sp = side_i;
    end else begin : g_next
      assign xp = x_q[gi-1];
      assign yp = y_q[gi-1];
      assign zp = z_q[gi-1];
      assign vp = v_q[gi-1];
      assign sp = s_q[gi-1];
    end

    always_comb begin
      if (!zp[CW-1]) begin
        xn = xp - (yp >>> gi);
        yn = yp + (xp >>> gi);
        zn = zp - cordic_atan(gi);
      end else begin
        xn = xp + (yp >>> gi);
        yn = yp - (xp >>> gi);
        zn = zp + cordic_atan(gi);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gi] <= 1'b0;
      end else if (en_i) begin
        v_q[gi] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[gi] <= xn;
        y_q[gi] <= yn;
        z_q[gi] <= zn;
        s_q[gi] <= sp;
      end
    end
  end

  assign valid_o = v_q[CORDIC_STEPS-1];
  assign side_o  = s_q[CORDIC_STEPS-1];
  assign cx_o    = x_q[CORDIC_STEPS-1];
  assign cy_o    = y_q[CORDIC_STEPS-1];

endmodule

>>> src/wmfp_div.sv
module wmfp_div import wmfp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  output logic                 valid_o,
  output side_t                side_o,
  output logic                 sat_o,
  output logic [DIV_BITS-1:0]  m_o
);

  // (1 + sin) / cos in q30, restoring division one quotient bit per stage
  logic signed [CW:0] num;
  logic               pv_q, psat_q;
  side_t              ps_q;
  logic [31:0]        pr_q, pd_q;
  logic [5:0]         pn_q;

  assign num = 34'sd1073741824 + {cy_i[CW-1], cy_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      psat_q <= (cx_i <= 0) || (num <= 0);
      pr_q   <= {6'd0, num[31:6]};
      pn_q   <= num[5:0];
      pd_q   <= cx_i[31:0];
      ps_q   <= side_i;
    end
  end

  logic [31:0]         r_q   [DIV_BITS];
  logic [31:0]         d_q   [DIV_BITS];
  logic [5:0]          n_q   [DIV_BITS];
  logic [DIV_BITS-1:0] q_q   [DIV_BITS];
  logic                sat_q [DIV_BITS];
  logic                v_q   [DIV_BITS];
  side_t               s_q   [DIV_BITS];

  for (genvar gj = 0; gj < DIV_BITS; gj++) begin : g_stage
    localparam int K = DIV_BITS - 1 - gj;
    logic [31:0]         rp, dp, rn;
    logic [5:0]          np;
    logic [DIV_BITS-1:0] qp;
    logic                satp, vp, nbit, ge;
    logic [32:0]         rr;
    side_t               sp;

    if (gj == 0) begin : g_first
      assign rp   = pr_q;
      assign dp   = pd_q;
      assign np   = pn_q;
      assign qp   = '0;
      assign satp = psat_q;
      assign vp   = pv_q;
      assign sp   = ps_q;
    end else begin : g_next
      assign rp   = r_q[gj-1];
      assign dp   = d_q[gj-1];
      assign np   = n_q[gj-1];
      assign qp   = q_q[gj-1];
      assign satp = sat_q[gj-1];
      assign vp   = v_q[gj-1];
      assign sp   = s_q[gj-1];
    end

    if (K >= 30) begin : g_num
      assign nbit = np[K-30];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    always_comb begin
      rr = {rp, nbit};
      ge = rr >= {1'b0, dp};
      rn = ge ? 32'(rr - {1'b0, dp}) : rr[31:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gj] <= 1'b0;
      end else if (en_i) begin
        v_q[gj] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[gj]   <= rn;
        d_q[gj]   <= dp;
        n_q[gj]   <= np;
        q_q[gj]   <= {qp[DIV_BITS-2:0], ge};
        sat_q[gj] <= satp;
        s_q[gj]   <= sp;
      end
    end
  end

  assign valid_o = v_q[DIV_BITS-1];
  assign side_o  = s_q[DIV_BITS-1];
  assign sat_o   = sat_q[DIV_BITS-1];
  assign m_o     = q_q[DIV_BITS-1];

endmodule

>>> src/wmfp_log2.sv
module wmfp_log2 import wmfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  side_t               side_i,
  input  logic                sat_i,
  input  logic [DIV_BITS-1:0] m_i,
  output logic                valid_o,
  output side_t               side_o,
  output logic [30:0]         p_o
);

  logic [2:0]  nn;
  logic        nv_q, nsat_q, nzero_q;
  logic [2:0]  nn_q;
  logic [30:0] nm_q;
  side_t       ns_q;

  always_comb begin
    if (m_i[35]) begin
      nn = 3'd5;
    end else if (m_i[34]) begin
      nn = 3'd4;
    end else if (m_i[33]) begin
      nn = 3'd3;
    end else if (m_i[32]) begin
      nn = 3'd2;
    end else if (m_i[31]) begin
      nn = 3'd1;
    end else begin
      nn = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else if (en_i) begin
      nv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nn_q    <= nn;
      nm_q    <= 31'(m_i >> nn);
      nzero_q <= (m_i[35:30] == 6'd0);
      nsat_q  <= sat_i;
      ns_q    <= side_i;
    end
  end

  // one fraction bit per squaring stage
  logic [30:0]          m_q    [LOG_STEPS];
  logic [LOG_STEPS-1:0] f_q    [LOG_STEPS];
  logic [2:0]           n_q    [LOG_STEPS];
  logic                 zero_q [LOG_STEPS];
  logic                 sat_q  [LOG_STEPS];
  logic                 v_q    [LOG_STEPS];
  side_t                s_q    [LOG_STEPS];

  for (genvar gi = 0; gi < LOG_STEPS; gi++) begin : g_stage
    logic [30:0]          mp, mn;
    logic [LOG_STEPS-1:0] fp;
    logic [2:0]           np;
    logic                 zp, satp, vp;
    logic [61:0]          sq;
    side_t                sp;

    if (gi == 0) begin : g_first
      assign mp   = nm_q;
      assign fp   = '0;
      assign np   = nn_q;
      assign zp   = nzero_q;
      assign satp = nsat_q;
      assign vp   = nv_q;
      assign sp   = ns_q;
    end else begin : g_next
      assign mp   = m_q[gi-1];
      assign fp   = f_q[gi-1];
      assign np   = n_q[gi-1];
      assign zp   = zero_q[gi-1];
      assign satp = sat_q[gi-1];
      assign vp   = v_q[gi-1];
      assign sp   = s_q[gi-1];
    end

    always_comb begin
      sq = mp * mp;
      mn = sq[61] ? sq[61:31] : sq[60:30];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gi] <= 1'b0;
      end else if (en_i) begin
        v_q[gi] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[gi]    <= mn;
        f_q[gi]    <= {fp[LOG_STEPS-2:0], sq[61]};
        n_q[gi]    <= np;
        zero_q[gi] <= zp;
        sat_q[gi]  <= satp;
        s_q[gi]    <= sp;
      end
    end
  end

  // psi / pi from log2 of the ratio
  logic [32:0] lg;
  logic [62:0] prod;
  logic [30:0] pr, pn;
  logic        pv_q;
  logic [30:0] p_q;
  side_t       ps_q;

  always_comb begin
    lg   = {n_q[LOG_STEPS-1], f_q[LOG_STEPS-1]};
    prod = lg * LN2_OVER_PI_Q32;
    pr   = prod[62:32];
    if (sat_q[LOG_STEPS-1]) begin
      pn = ONE_Q30;
    end else if (zero_q[LOG_STEPS-1]) begin
      pn = '0;
    end else if (pr > ONE_Q30) begin
      pn = ONE_Q30;
    end else begin
      pn = pr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= v_q[LOG_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q  <= pn;
      ps_q <= s_q[LOG_STEPS-1];
    end
  end

  assign valid_o = pv_q;
  assign side_o  = ps_q;
  assign p_o     = p_q;

endmodule

>>> src/wmfp_xdiv.sv
module wmfp_xdiv import wmfp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [V_W-1:0]   v_i,
  input  logic [OUT_W-1:0] y_i,
  output logic             valid_o,
  output logic [OUT_W-1:0] x_o,
  output logic [OUT_W-1:0] y_o
);

  // v / 360 as (v >> 3) / 45, multiplied by ceil(2^46 / 45) in four partial products
  logic [39:0]      a;
  logic             v1_q, v2_q, v3_q;
  logic [40:0]      hh1_q, lh1_q;
  logic [39:0]      hl1_q, ll1_q;
  logic [40:0]      hh2_q;
  logic [42:0]      mid2_q;
  logic [60:0]      sum;
  logic [OUT_W-1:0] y1_q, y2_q, y3_q, x3_q;

  assign a   = v_i[V_W-1:3];
  assign sum = {hh2_q, 20'd0} + {18'd0, mid2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh1_q  <= a[39:20] * X_RECIP[40:20];
      hl1_q  <= a[39:20] * X_RECIP[19:0];
      lh1_q  <= a[19:0] * X_RECIP[40:20];
      ll1_q  <= a[19:0] * X_RECIP[19:0];
      y1_q   <= y_i;
      hh2_q  <= hh1_q;
      mid2_q <= {3'd0, hl1_q} + {2'd0, lh1_q} + {23'd0, ll1_q[39:20]};
      y2_q   <= y1_q;
      x3_q   <= sum[60:26];
      y3_q   <= y2_q;
    end
  end

  assign valid_o = v3_q;
  assign x_o     = x3_q;
  assign y_o     = y3_q;

endmodule

>>> src/wmfp_checker.sv
module wmfp_port_checks import wmfp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request side stalled with empty output");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[34:0] <= 35'h400000000)
    else $error("pixel x beyond map width");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[69:35] <= 35'h400000000)
    else $error("pixel y beyond map height");

endmodule

bind web_mercator_forward_projection_core wmfp_port_checks u_wmfp_port_checks (.*);
